>>> design/adp_pkg.sv
package adp_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'ha,
    OP_CMN = 4'hb,
    OP_ORR = 4'hc,
    OP_MOV = 4'hd,
    OP_BIC = 4'he,
    OP_MVN = 4'hf
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_e;

  localparam logic [3:0] PC_INDEX = 4'hf;
  localparam logic [7:0] PC_SHIFT_ADJ = 8'd8;
  localparam logic [7:0] PC_SHIFT_MASK = 8'hfc;
  localparam logic [7:0] SHIFT_FULL = 8'd32;

  typedef struct packed {
    logic [31:0] value;
    logic        carry;
  } shift_res_t;

endpackage

>>> design/adp_operand2.sv
module adp_operand2 import adp_pkg::*; (
  input  logic        imm_form_i,
  input  logic [11:0] op2_field_i,
  input  logic [31:0] rm_i,
  input  logic [7:0]  rs_low_i,
  input  logic        carry_i,
  output shift_res_t  op2_o
);

  shift_kind_e kind;
  logic [7:0]  rs_amt;
  logic [4:0]  imm_amt;
  logic [4:0]  sm_amt;
  logic [4:0]  rot_amt;
  logic [63:0] imm_dbl;
  logic [63:0] imm_shr;
  logic [63:0] rm_dbl;
  logic [63:0] rm_shr;
  logic        reg_form;
  shift_res_t  part_sh;

  assign kind     = shift_kind_e'(op2_field_i[6:5]);
  assign reg_form = op2_field_i[4];
  assign imm_amt  = op2_field_i[11:7];
  assign rs_amt   = (op2_field_i[11:8] == PC_INDEX) ?
                    ((rs_low_i + PC_SHIFT_ADJ) & PC_SHIFT_MASK) : rs_low_i;
  assign sm_amt   = reg_form ? rs_amt[4:0] : imm_amt;

  assign rot_amt  = {op2_field_i[11:8], 1'b0};
  assign imm_dbl  = {24'd0, op2_field_i[7:0], 24'd0, op2_field_i[7:0]};
  assign imm_shr  = imm_dbl >> rot_amt;
  assign rm_dbl   = {rm_i, rm_i};
  assign rm_shr   = rm_dbl >> sm_amt;

  // shift by 1..31
  always_comb begin
    case (kind)
      SH_LSL: begin
        part_sh.value = rm_i << sm_amt;
        part_sh.carry = rm_i[5'd0 - sm_amt];
      end
      SH_LSR: begin
        part_sh.value = rm_i >> sm_amt;
        part_sh.carry = rm_i[sm_amt - 5'd1];
      end
      SH_ASR: begin
        part_sh.value = $signed(rm_i) >>> sm_amt;
        part_sh.carry = rm_i[sm_amt - 5'd1];
      end
      default: begin
        part_sh.value = rm_shr[31:0];
        part_sh.carry = rm_i[sm_amt - 5'd1];
      end
    endcase
  end

  always_comb begin
    op2_o = part_sh;
    if (imm_form_i) begin
      op2_o.value = imm_shr[31:0];
      op2_o.carry = carry_i;
    end else if (!reg_form) begin
      if (imm_amt == 5'd0) begin
        case (kind)
          SH_LSL: begin
            op2_o.value = rm_i;
            op2_o.carry = carry_i;
          end
          SH_LSR: begin
            op2_o.value = 32'd0;
            op2_o.carry = rm_i[31];
          end
          SH_ASR: begin
            op2_o.value = {32{rm_i[31]}};
            op2_o.carry = rm_i[31];
          end
          default: begin
            op2_o.value = {carry_i, rm_i[31:1]};
            op2_o.carry = rm_i[0];
          end
        endcase
      end
    end else if (rs_amt == 8'd0) begin
      op2_o.value = rm_i;
      op2_o.carry = carry_i;
    end else if (rs_amt[7:5] != 3'd0) begin
      case (kind)
        SH_LSL: begin
          op2_o.value = 32'd0;
          op2_o.carry = (rs_amt == SHIFT_FULL) & rm_i[0];
        end
        SH_LSR: begin
          op2_o.value = 32'd0;
          op2_o.carry = (rs_amt == SHIFT_FULL) & rm_i[31];
        end
        SH_ASR: begin
          op2_o.value = {32{rm_i[31]}};
          op2_o.carry = rm_i[31];
        end
        default: begin
          if (rs_amt[4:0] == 5'd0) begin
            op2_o.value = rm_i;
            op2_o.carry = rm_i[31];
          end
        end
      endcase
    end
  end

endmodule

>>> design/arm_data_processing_alu.sv
// Items pass the input register, then the result register, at one item per cycle
// unless stalled; a new item enters an empty input register while a result waits.
// The whole path stalls only when both the input and result registers are full.
// Reset (rst_ni low, asynchronous) empties both registers; payload is not reset.
module arm_data_processing_alu import adp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] rn_value_i,
  input  logic [31:0] rm_value_i,
  input  logic [31:0] rs_value_i,
  input  logic        flag_n_in_i,
  input  logic        flag_z_in_i,
  input  logic        flag_c_in_i,
  input  logic        flag_v_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o,
  output logic [3:0]  dest_index_o,
  output logic        write_result_o,
  output logic        flags_update_o,
  output logic        flag_n_out_o,
  output logic        flag_z_out_o,
  output logic        flag_c_out_o,
  output logic        flag_v_out_o
);

  logic        s1_valid_q;
  logic [31:0] instr_q;
  logic [31:0] rn_q;
  logic [31:0] rm_q;
  logic [7:0]  rs_q;
  logic [3:0]  flags_q;

  logic        advance;
  logic        in_fire;
  shift_res_t  op2;
  alu_op_e     opcode;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_ci;
  logic [32:0] sum;
  logic        arith;
  logic [31:0] res_d;
  logic        c_d;
  logic        v_d;
  logic        upd_d;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      instr_q <= instruction_i;
      rn_q    <= rn_value_i;
      rm_q    <= rm_value_i;
      rs_q    <= rs_value_i[7:0];
      flags_q <= {flag_n_in_i, flag_z_in_i, flag_c_in_i, flag_v_in_i};
    end
  end

  adp_operand2 u_operand2 (
    .imm_form_i  (instr_q[25]),
    .op2_field_i (instr_q[11:0]),
    .rm_i        (rm_q),
    .rs_low_i    (rs_q),
    .carry_i     (flags_q[1]),
    .op2_o       (op2)
  );

  assign opcode = alu_op_e'(instr_q[24:21]);

  always_comb begin
    add_a  = rn_q;
    add_b  = op2.value;
    add_ci = 1'b0;
    arith  = 1'b1;
    case (opcode)
      OP_SUB, OP_CMP: begin
        add_b  = ~op2.value;
        add_ci = 1'b1;
      end
      OP_RSB: begin
        add_a  = op2.value;
        add_b  = ~rn_q;
        add_ci = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        add_ci = 1'b0;
      end
      OP_ADC: begin
        add_ci = flags_q[1];
      end
      OP_SBC: begin
        add_b  = ~op2.value;
        add_ci = flags_q[1];
      end
      OP_RSC: begin
        add_a  = op2.value;
        add_b  = ~rn_q;
        add_ci = flags_q[1];
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};

  always_comb begin
    case (opcode)
      OP_AND, OP_TST: res_d = rn_q & op2.value;
      OP_EOR, OP_TEQ: res_d = rn_q ^ op2.value;
      OP_ORR:         res_d = rn_q | op2.value;
      OP_MOV:         res_d = op2.value;
      OP_BIC:         res_d = rn_q & ~op2.value;
      OP_MVN:         res_d = ~op2.value;
      default:        res_d = sum[31:0];
    endcase
  end

  assign c_d   = arith ? sum[32] : op2.carry;
  assign v_d   = arith ? ((~(add_a[31] ^ add_b[31])) & (add_a[31] ^ sum[31])) : flags_q[0];
  assign upd_d = instr_q[20] && (instr_q[15:12] != PC_INDEX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      result_o       <= res_d;
      dest_index_o   <= instr_q[15:12];
      write_result_o <= (instr_q[24:23] != 2'b10);
      flags_update_o <= upd_d;
      if (upd_d) begin
        flag_n_out_o <= res_d[31];
        flag_z_out_o <= (res_d == 32'd0);
        flag_c_out_o <= c_d;
        flag_v_out_o <= v_d;
      end else begin
        flag_n_out_o <= flags_q[3];
        flag_z_out_o <= flags_q[2];
        flag_c_out_o <= flags_q[1];
        flag_v_out_o <= flags_q[0];
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("input stage item dropped during stall");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item not captured");

  a_no_pc_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(flags_update_o && (dest_index_o == PC_INDEX)))
    else $error("flags update with PC destination");

  a_nz_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flags_update_o |->
      (flag_n_out_o == result_o[31]) && (flag_z_out_o == (result_o == 32'd0)))
    else $error("N or Z flag does not match result");
`endif

endmodule
